// File: rtl/pdwbl_pkg.sv
// ----------------------------------------------------------------------------
// pdwbl_pkg
// Types and constants shared by the pseudo-DMA word/byte latch modules.
// ----------------------------------------------------------------------------
package pdwbl_pkg;

    localparam int CMD_W    = 3;
    localparam int OFFSET_W = 6;
    localparam int WORD_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 2;
    localparam int REGIDX_W = 3;
    localparam int ID_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // item commands
    localparam logic [CMD_W-1:0] CMD_REG_WRITE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DMA_READ   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DMA_WRITE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DRQ_CHANGE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_IRQ_CHANGE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_STATUS     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_BUS_RESET  = 3'd6;

    // controller registers that arm the latch
    localparam logic [REGIDX_W-1:0] REG_ARM_TO_CTRL   = 3'd5;
    localparam logic [REGIDX_W-1:0] REG_ARM_FROM_CTRL = 3'd7;
    localparam int OFFSET_CLEAR_BIT = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCSI_ID      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHING_ON   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SPINUP = 2'd2;

    localparam logic [ID_W-1:0]   SCSI_ID_RESET  = 3'd7;
    localparam logic [WORD_W-1:0] WORD_EMPTY     = 16'hffff;
    localparam logic [COUNT_W-1:0] WORD_BYTES    = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0] scsi_id;
        logic            caching_on;
        logic            short_spinup;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [OFFSET_W-1:0] reg_offset;
        logic [WORD_W-1:0]   data_word;
        logic                line_level;
        logic [COUNT_W-1:0]  ncr_bytes_ready;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0]   read_word;
        logic [COUNT_W-1:0]  ncr_byte_count;
        logic [BYTE_W-1:0]   ncr_byte_first;
        logic [BYTE_W-1:0]   ncr_byte_second;
        logic [COUNT_W-1:0]  ncr_bytes_taken;
        logic                reg_forward_valid;
        logic [REGIDX_W-1:0] reg_index;
        logic [BYTE_W-1:0]   reg_data;
        logic                host_ready;
        logic [BYTE_W-1:0]   status_byte;
    } res_t;

    typedef struct packed {
        logic [WORD_W-1:0]  holding_word;
        logic [COUNT_W-1:0] bytes_left;
        logic               dma_active;
        logic               word_done_by_drq;
        logic               direction_write;
        logic               drq_seen;
        logic               ready_level;
    } state_t;

endpackage

// File: rtl/pdwbl_if.sv
// ----------------------------------------------------------------------------
// pdwbl_if
// Valid/ready channels for the latch: one for input items, one for results.
// ----------------------------------------------------------------------------
interface pdwbl_in_if
    import pdwbl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [OFFSET_W-1:0] reg_offset;
    logic [WORD_W-1:0]   data_word;
    logic                line_level;
    logic [COUNT_W-1:0]  ncr_bytes_ready;

    modport source (output valid, cmd, reg_offset, data_word, line_level, ncr_bytes_ready,
                    input ready);
    modport sink   (input valid, cmd, reg_offset, data_word, line_level, ncr_bytes_ready,
                    output ready);
endinterface

interface pdwbl_out_if
    import pdwbl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   read_word;
    logic [COUNT_W-1:0]  ncr_byte_count;
    logic [BYTE_W-1:0]   ncr_byte_first;
    logic [BYTE_W-1:0]   ncr_byte_second;
    logic [COUNT_W-1:0]  ncr_bytes_taken;
    logic                reg_forward_valid;
    logic [REGIDX_W-1:0] reg_index;
    logic [BYTE_W-1:0]   reg_data;
    logic                host_ready;
    logic [BYTE_W-1:0]   status_byte;

    modport source (output valid, read_word, ncr_byte_count, ncr_byte_first,
                    ncr_byte_second, ncr_bytes_taken, reg_forward_valid, reg_index,
                    reg_data, host_ready, status_byte,
                    input ready);
    modport sink   (input valid, read_word, ncr_byte_count, ncr_byte_first,
                    ncr_byte_second, ncr_bytes_taken, reg_forward_valid, reg_index,
                    reg_data, host_ready, status_byte,
                    output ready);
endinterface

// File: rtl/pdwbl_core.sv
// ----------------------------------------------------------------------------
// pdwbl_core
// Latch state registers and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
module pdwbl_core
    import pdwbl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  item_t  item,
    input  logic   fire,
    output res_t   res
);

    state_t             st_reg;
    state_t             st_next;
    logic [COUNT_W-1:0] burst;
    logic [COUNT_W-1:0] moved;
    logic [REGIDX_W-1:0] reg_sel;
    logic               rising;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.holding_word     <= WORD_EMPTY;
            st_reg.bytes_left       <= '0;
            st_reg.dma_active       <= 1'b0;
            st_reg.word_done_by_drq <= 1'b0;
            st_reg.direction_write  <= 1'b0;
            st_reg.drq_seen         <= 1'b0;
            st_reg.ready_level      <= 1'b1;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

    // bytes that move in one host access: none unless drq is high, at most two
    assign burst   = (item.ncr_bytes_ready == 2'd3) ? WORD_BYTES : item.ncr_bytes_ready;
    assign moved   = st_reg.drq_seen ? burst : 2'd0;
    assign reg_sel = item.reg_offset[3:1];
    assign rising  = !st_reg.drq_seen && item.line_level;

    always_comb
    begin
        st_next = st_reg;
        res     = '0;
        res.read_word = WORD_EMPTY;

        case (item.cmd)
            CMD_REG_WRITE:
            begin
                if (reg_sel == REG_ARM_TO_CTRL || reg_sel == REG_ARM_FROM_CTRL)
                begin
                    st_next.dma_active       = 1'b1;
                    st_next.word_done_by_drq = 1'b0;
                    st_next.direction_write  = (reg_sel == REG_ARM_TO_CTRL);
                end
                if (reg_sel == REG_ARM_FROM_CTRL && item.reg_offset[OFFSET_CLEAR_BIT])
                begin
                    st_next.holding_word = WORD_EMPTY;
                    st_next.bytes_left   = '0;
                end
                res.reg_forward_valid = 1'b1;
                res.reg_index         = reg_sel;
                res.reg_data          = item.data_word[BYTE_W-1:0];
            end
            CMD_DMA_READ:
            begin
                if (st_reg.word_done_by_drq)
                begin
                    st_next.word_done_by_drq = 1'b0;
                    res.read_word            = st_reg.holding_word;
                end
                else if (st_reg.dma_active)
                begin
                    // a short burst means the controller dropped drq
                    st_next.drq_seen   = (moved == WORD_BYTES);
                    st_next.bytes_left = WORD_BYTES - moved;
                    res.ncr_bytes_taken = moved;
                    case (moved)
                        2'd0:    st_next.holding_word = WORD_EMPTY;
                        2'd1:    st_next.holding_word = {8'hff, item.data_word[15:8]};
                        default: st_next.holding_word = item.data_word;
                    endcase
                    if (moved == WORD_BYTES)
                    begin
                        res.read_word = item.data_word;
                    end
                    else
                    begin
                        st_next.ready_level = 1'b0;
                    end
                end
            end
            CMD_DMA_WRITE:
            begin
                if (st_reg.word_done_by_drq)
                begin
                    st_next.word_done_by_drq = 1'b0;
                end
                else if (st_reg.dma_active)
                begin
                    st_next.drq_seen   = (moved == WORD_BYTES);
                    st_next.bytes_left = WORD_BYTES - moved;
                    res.ncr_byte_count = moved;
                    case (moved)
                        2'd0:
                        begin
                            st_next.holding_word = item.data_word;
                        end
                        2'd1:
                        begin
                            st_next.holding_word = {item.data_word[7:0], 8'h00};
                            res.ncr_byte_first   = item.data_word[15:8];
                        end
                        default:
                        begin
                            st_next.holding_word = '0;
                            res.ncr_byte_first   = item.data_word[15:8];
                            res.ncr_byte_second  = item.data_word[7:0];
                        end
                    endcase
                    if (moved != WORD_BYTES)
                    begin
                        st_next.ready_level = 1'b0;
                    end
                end
            end
            CMD_DRQ_CHANGE:
            begin
                st_next.drq_seen = item.line_level;
                if (rising && st_reg.bytes_left != 2'd0)
                begin
                    if (st_reg.direction_write)
                    begin
                        res.ncr_byte_count   = 2'd1;
                        res.ncr_byte_first   = st_reg.holding_word[15:8];
                        st_next.holding_word = {st_reg.holding_word[7:0], 8'h00};
                    end
                    else
                    begin
                        res.ncr_bytes_taken  = 2'd1;
                        st_next.holding_word = {st_reg.holding_word[7:0],
                                                item.data_word[15:8]};
                    end
                    st_next.bytes_left = st_reg.bytes_left - 2'd1;
                    if (st_reg.bytes_left == 2'd1)
                    begin
                        st_next.word_done_by_drq = 1'b1;
                        st_next.ready_level      = 1'b1;
                    end
                end
            end
            CMD_IRQ_CHANGE:
            begin
                if (item.line_level)
                begin
                    st_next.dma_active  = 1'b0;
                    st_next.bytes_left  = '0;
                    st_next.ready_level = 1'b1;
                end
            end
            CMD_STATUS:
            begin
                res.status_byte = {(st_reg.bytes_left == 2'd0), st_reg.drq_seen,
                                   cfg.short_spinup, cfg.caching_on, 1'b0, ~cfg.scsi_id};
            end
            CMD_BUS_RESET:
            begin
                st_next.holding_word     = WORD_EMPTY;
                st_next.bytes_left       = '0;
                st_next.dma_active       = 1'b0;
                st_next.word_done_by_drq = 1'b0;
                st_next.drq_seen         = 1'b0;
                st_next.ready_level      = 1'b1;
            end
            default:
            begin
                st_next = st_reg;
            end
        endcase

        res.host_ready = st_next.ready_level;
    end

endmodule

// File: rtl/pdwbl_out_stage.sv
// ----------------------------------------------------------------------------
// pdwbl_out_stage
// Result register driving the result channel; takes a new result when free.
// ----------------------------------------------------------------------------
module pdwbl_out_stage
    import pdwbl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  res_t        res,
    output logic        free,
    pdwbl_out_if.source result_ch
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign free       = !valid_reg || result_ch.ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !result_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign result_ch.valid             = valid_reg;
    assign result_ch.read_word         = res_reg.read_word;
    assign result_ch.ncr_byte_count    = res_reg.ncr_byte_count;
    assign result_ch.ncr_byte_first    = res_reg.ncr_byte_first;
    assign result_ch.ncr_byte_second   = res_reg.ncr_byte_second;
    assign result_ch.ncr_bytes_taken   = res_reg.ncr_bytes_taken;
    assign result_ch.reg_forward_valid = res_reg.reg_forward_valid;
    assign result_ch.reg_index         = res_reg.reg_index;
    assign result_ch.reg_data          = res_reg.reg_data;
    assign result_ch.host_ready        = res_reg.host_ready;
    assign result_ch.status_byte       = res_reg.status_byte;

endmodule

// File: rtl/pseudo_dma_word_byte_latch.sv
// ----------------------------------------------------------------------------
// pseudo_dma_word_byte_latch
// Pseudo-DMA latch between a 16-bit host bus and an 8-bit controller DMA port.
//
//   channel    dir   handshake          payload
//   item_ch    in    valid/ready        cmd, reg_offset, data_word, line_level,
//                                       ncr_bytes_ready
//   result_ch  out   valid/ready        read_word .. status_byte
//   cfg        in    cfg_we (no wait)   cfg_index, cfg_data
//
// an item goes input register -> latch logic -> result register, which holds
// the result; one item per cycle sustained while the result channel is ready
// the result register sets the rate; a stalled result holds the input register,
// which then holds ready low
// reset leaves holding word 0xffff, host ready high, jumpers at 7/0/1
// ----------------------------------------------------------------------------
module pseudo_dma_word_byte_latch
    import pdwbl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pdwbl_in_if.sink              item_ch,
    pdwbl_out_if.source           result_ch
);

    cfg_t  cfg_reg;
    item_t item_reg;
    item_t item_in;
    logic  item_valid_reg;
    logic  item_valid_next;
    logic  out_free;
    logic  fire;
    res_t  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scsi_id      <= SCSI_ID_RESET;
            cfg_reg.caching_on   <= 1'b0;
            cfg_reg.short_spinup <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCSI_ID:      cfg_reg.scsi_id      <= cfg_data;
                CFG_CACHING_ON:   cfg_reg.caching_on   <= cfg_data[0];
                CFG_SHORT_SPINUP: cfg_reg.short_spinup <= cfg_data[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign fire            = item_valid_reg && out_free;
    assign item_ch.ready   = !item_valid_reg || fire;
    assign item_valid_next = item_ch.valid || (item_valid_reg && !fire);

    assign item_in.cmd             = item_ch.cmd;
    assign item_in.reg_offset      = item_ch.reg_offset;
    assign item_in.data_word       = item_ch.data_word;
    assign item_in.line_level      = item_ch.line_level;
    assign item_in.ncr_bytes_ready = item_ch.ncr_bytes_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ch.ready)
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ch.valid && item_ch.ready)
        begin
            item_reg <= item_in;
        end
    end

    pdwbl_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .item  (item_reg),
        .fire  (fire),
        .res   (res)
    );

    pdwbl_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res       (res),
        .free      (out_free),
        .result_ch (result_ch)
    );

endmodule

// File: rtl/pdwbl_checker.sv
// ----------------------------------------------------------------------------
// pdwbl_checker
// Port-level checks on the latch result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pdwbl_checker
    import pdwbl_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [COUNT_W-1:0]  ncr_byte_count,
    input logic [BYTE_W-1:0]   ncr_byte_first,
    input logic [BYTE_W-1:0]   ncr_byte_second,
    input logic [COUNT_W-1:0]  ncr_bytes_taken,
    input logic                reg_forward_valid,
    input logic [REGIDX_W-1:0] reg_index,
    input logic [BYTE_W-1:0]   reg_data
);

    // a stalled result stays valid and keeps its first byte and register data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ncr_byte_first)
            && $stable(reg_data))
        else $error("result changed while stalled");

    // no forwarded write means empty index and data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reg_forward_valid |-> reg_index == 3'd0 && reg_data == 8'd0)
        else $error("register fields set without a forwarded write");

    // bytes not pushed read as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ncr_byte_count != WORD_BYTES |-> ncr_byte_second == 8'd0
            && (ncr_byte_count != 2'd0 || ncr_byte_first == 8'd0))
        else $error("unpushed byte not zero");

    // one item never both pushes and takes controller bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ncr_byte_count == 2'd0 || ncr_bytes_taken == 2'd0)
        else $error("push and take in one item");

endmodule

bind pseudo_dma_word_byte_latch pdwbl_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (result_ch.valid),
    .out_ready         (result_ch.ready),
    .ncr_byte_count    (result_ch.ncr_byte_count),
    .ncr_byte_first    (result_ch.ncr_byte_first),
    .ncr_byte_second   (result_ch.ncr_byte_second),
    .ncr_bytes_taken   (result_ch.ncr_bytes_taken),
    .reg_forward_valid (result_ch.reg_forward_valid),
    .reg_index         (result_ch.reg_index),
    .reg_data          (result_ch.reg_data)
);

// File: tb/tb_pseudo_dma_word_byte_latch.sv
// ----------------------------------------------------------------------------
// tb_pseudo_dma_word_byte_latch
// Drives host and controller events into the pseudo-DMA latch through the
// item channel and checks every result against a cycle-free model of the
// latch or the typed row's own result. A directed table comes first, then
// armed transfer bursts mixed with noise, over four phases of sender idling
// and receiver stalls and several jumper settings.
// ----------------------------------------------------------------------------
module tb_pseudo_dma_word_byte_latch;
    import pdwbl_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int LIMIT_CYCLES = 400000;
    localparam int ITEMS_PER_PHASE = 235;

    typedef struct packed {
        item_t               it;
        logic                typed;
        logic [WORD_W-1:0]   t_read;
        logic                t_fwd;
        logic [REGIDX_W-1:0] t_idx;
        logic [BYTE_W-1:0]   t_data;
        logic [BYTE_W-1:0]   t_status;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pdwbl_in_if  item_ch();
    pdwbl_out_if result_ch();

    pseudo_dma_word_byte_latch dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item_ch   (item_ch),
        .result_ch (result_ch)
    );

    // latch model state
    logic [WORD_W-1:0]  hold_word;
    logic [COUNT_W-1:0] left;
    logic               armed;
    logic               done_by_drq;
    logic               dir_wr;
    logic               drq_level;
    logic               rdy;
    logic [ID_W-1:0]    jp_id;
    logic               jp_cache;
    logic               jp_spin;

    res_t      pending[$];
    plan_row_t plan[$];
    int        items_sent = 0;
    int        failures = 0;
    int        reports = 0;
    int        cycles = 0;
    int        sender_idle_pct = 0;
    int        stall_pct = 0;
    int        hold_request = 0;
    int        hold_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic res_t latch_response(item_t it);
        res_t               r;
        logic [COUNT_W-1:0] lim;
        logic [COUNT_W-1:0] k;
        logic               rising;
        logic [REGIDX_W-1:0] rix;
        r = '0;
        r.read_word = WORD_EMPTY;
        lim = (it.ncr_bytes_ready == 2'd3) ? WORD_BYTES : it.ncr_bytes_ready;
        k = '0;
        case (it.cmd)
            CMD_REG_WRITE:
            begin
                rix = it.reg_offset[3:1];
                if (rix == REG_ARM_TO_CTRL || rix == REG_ARM_FROM_CTRL)
                begin
                    armed = 1'b1;
                    done_by_drq = 1'b0;
                    dir_wr = (rix == REG_ARM_TO_CTRL);
                end
                if (rix == REG_ARM_FROM_CTRL && it.reg_offset[OFFSET_CLEAR_BIT])
                begin
                    hold_word = WORD_EMPTY;
                    left = '0;
                end
                r.reg_forward_valid = 1'b1;
                r.reg_index = rix;
                r.reg_data = it.data_word[7:0];
            end
            CMD_DMA_READ:
            begin
                if (done_by_drq)
                begin
                    done_by_drq = 1'b0;
                    r.read_word = hold_word;
                end
                else if (armed)
                begin
                    hold_word = WORD_EMPTY;
                    left = WORD_BYTES;
                    for (int i = 0; i < 2; i++)
                    begin
                        if (drq_level && left != 0)
                        begin
                            // controller ran dry while drq was high
                            if (k >= lim)
                                drq_level = 1'b0;
                            else
                            begin
                                hold_word = {hold_word[7:0],
                                             (k == 0) ? it.data_word[15:8] : it.data_word[7:0]};
                                k++;
                                left--;
                            end
                        end
                    end
                    r.ncr_bytes_taken = k;
                    if (left == 0)
                        r.read_word = hold_word;
                    else
                        rdy = 1'b0;
                end
            end
            CMD_DMA_WRITE:
            begin
                if (done_by_drq)
                    done_by_drq = 1'b0;
                else if (armed)
                begin
                    hold_word = it.data_word;
                    left = WORD_BYTES;
                    for (int i = 0; i < 2; i++)
                    begin
                        if (drq_level && left != 0)
                        begin
                            if (k >= lim)
                                drq_level = 1'b0;
                            else
                            begin
                                if (k == 0)
                                    r.ncr_byte_first = hold_word[15:8];
                                else
                                    r.ncr_byte_second = hold_word[15:8];
                                hold_word = hold_word << 8;
                                k++;
                                left--;
                            end
                        end
                    end
                    r.ncr_byte_count = k;
                    if (left != 0)
                        rdy = 1'b0;
                end
            end
            CMD_DRQ_CHANGE:
            begin
                rising = !drq_level && it.line_level;
                drq_level = it.line_level;
                // a rising edge moves one byte, armed or not
                if (rising && left != 0)
                begin
                    if (dir_wr)
                    begin
                        r.ncr_byte_first = hold_word[15:8];
                        r.ncr_byte_count = 2'd1;
                        hold_word = hold_word << 8;
                    end
                    else
                    begin
                        hold_word = {hold_word[7:0], it.data_word[15:8]};
                        r.ncr_bytes_taken = 2'd1;
                    end
                    left--;
                    if (left == 0)
                    begin
                        done_by_drq = 1'b1;
                        rdy = 1'b1;
                    end
                end
            end
            CMD_IRQ_CHANGE:
            begin
                if (it.line_level)
                begin
                    armed = 1'b0;
                    left = '0;
                    rdy = 1'b1;
                end
            end
            CMD_STATUS:
                r.status_byte = {left == 0, drq_level, jp_spin, jp_cache, 1'b0, ~jp_id};
            CMD_BUS_RESET:
            begin
                hold_word = WORD_EMPTY;
                left = '0;
                armed = 1'b0;
                done_by_drq = 1'b0;
                drq_level = 1'b0;
                rdy = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.host_ready = rdy;
        return r;
    endfunction

    function automatic item_t noise_item();
        item_t it;
        it.cmd = CMD_W'($urandom_range(7));
        it.reg_offset = OFFSET_W'($urandom_range(63));
        it.data_word = WORD_W'($urandom);
        it.line_level = 1'($urandom_range(1));
        it.ncr_bytes_ready = COUNT_W'($urandom_range(3));
        return it;
    endfunction

    function automatic item_t line_item(logic [CMD_W-1:0] c, logic lvl);
        item_t it;
        it = noise_item();
        it.cmd = c;
        it.line_level = lvl;
        return it;
    endfunction

    task automatic send(item_t it, bit typed = 1'b0, res_t typed_res = '0);
        res_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.cmd <= it.cmd;
        item_ch.reg_offset <= it.reg_offset;
        item_ch.data_word <= it.data_word;
        item_ch.line_level <= it.line_level;
        item_ch.ncr_bytes_ready <= it.ncr_bytes_ready;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predicted = latch_response(it);
        pending.push_back(typed ? typed_res : predicted);
        if (it.cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_jumpers(logic [ID_W-1:0] id, logic cache, logic spin);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SCSI_ID;
        cfg_data <= CFG_DATA_W'(id);
        @(posedge clk);
        jp_id = id;
        cfg_index <= CFG_CACHING_ON;
        cfg_data <= CFG_DATA_W'(cache);
        @(posedge clk);
        jp_cache = cache;
        cfg_index <= CFG_SHORT_SPINUP;
        cfg_data <= CFG_DATA_W'(spin);
        @(posedge clk);
        jp_spin = spin;
        cfg_we <= 1'b0;
    endtask

    // arm the latch, then move a few words with drq edges and acknowledges
    task automatic transfer_burst();
        item_t it;
        bit    to_ctrl;
        int    tries;
        it = noise_item();
        it.cmd = CMD_REG_WRITE;
        to_ctrl = 1'($urandom_range(1));
        it.reg_offset[3:1] = to_ctrl ? REG_ARM_TO_CTRL : REG_ARM_FROM_CTRL;
        send(it);
        repeat ($urandom_range(1, 5))
        begin
            if ($urandom_range(3) != 0)
                send(line_item(CMD_DRQ_CHANGE, 1'b1));
            it = noise_item();
            it.cmd = (to_ctrl ^ ($urandom_range(9) == 0)) ? CMD_DMA_WRITE : CMD_DMA_READ;
            send(it);
            tries = 0;
            while (left != 0 && tries < 4)
            begin
                send(line_item(CMD_DRQ_CHANGE, 1'b0));
                send(line_item(CMD_DRQ_CHANGE, 1'b1));
                tries++;
            end
            if ($urandom_range(9) == 0)
                send(line_item(CMD_IRQ_CHANGE, 1'($urandom_range(1))));
            if ($urandom_range(4) == 0)
                send(line_item(CMD_STATUS, 1'b0));
            // acknowledge the word finished by drq
            it = noise_item();
            it.cmd = to_ctrl ? CMD_DMA_WRITE : CMD_DMA_READ;
            send(it);
        end
    endtask

    // result side: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_request > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left = hold_request;
            hold_request = 0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = {result_ch.read_word, result_ch.ncr_byte_count, result_ch.ncr_byte_first,
                   result_ch.ncr_byte_second, result_ch.ncr_bytes_taken,
                   result_ch.reg_forward_valid, result_ch.reg_index, result_ch.reg_data,
                   result_ch.host_ready, result_ch.status_byte};
            if (pending.size() == 0)
            begin
                failures++;
                if (reports < 10)
                begin
                    reports++;
                    $display("unexpected result %h at cycle %0d", got, cycles);
                end
            end
            else
            begin
                want = pending.pop_front();
                if (got !== want)
                begin
                    failures++;
                    if (reports < 10)
                    begin
                        reports++;
                        $display({"mismatch at cycle %0d\n",
                                  "  exp rd=%h cnt=%0d b0=%h b1=%h tk=%0d fwd=%b idx=%0d ",
                                  "dat=%h rdy=%b st=%h\n",
                                  "  got rd=%h cnt=%0d b0=%h b1=%h tk=%0d fwd=%b idx=%0d ",
                                  "dat=%h rdy=%b st=%h"}, cycles,
                                 want.read_word, want.ncr_byte_count, want.ncr_byte_first,
                                 want.ncr_byte_second, want.ncr_bytes_taken,
                                 want.reg_forward_valid, want.reg_index, want.reg_data,
                                 want.host_ready, want.status_byte,
                                 got.read_word, got.ncr_byte_count, got.ncr_byte_first,
                                 got.ncr_byte_second, got.ncr_bytes_taken,
                                 got.reg_forward_valid, got.reg_index, got.reg_data,
                                 got.host_ready, got.status_byte);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb_pseudo_dma_word_byte_latch failed");
            $finish;
        end
    end

    initial
    begin
        plan_row_t row;
        res_t      tr;
        int        target;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.cmd = CMD_REG_WRITE;
        item_ch.reg_offset = '0;
        item_ch.data_word = '0;
        item_ch.line_level = 1'b0;
        item_ch.ncr_bytes_ready = '0;
        result_ch.ready = 1'b0;

        hold_word = WORD_EMPTY;
        left = '0;
        armed = 1'b0;
        done_by_drq = 1'b0;
        dir_wr = 1'b0;
        drq_level = 1'b0;
        rdy = 1'b1;
        jp_id = SCSI_ID_RESET;
        jp_cache = 1'b0;
        jp_spin = 1'b1;

        // cmd, offset, data, level, ready | typed, read, fwd, idx, data, status
        // status straight after reset
        plan.push_back({CMD_STATUS, 6'h00, 16'h0000, 1'b0, 2'd0,
                        1'b1, 16'hffff, 1'b0, 3'd0, 8'h00, 8'ha0});
        // accesses while not armed
        plan.push_back({CMD_DMA_READ, 6'h00, 16'h0000, 1'b0, 2'd3,
                        1'b1, 16'hffff, 1'b0, 3'd0, 8'h00, 8'h00});
        plan.push_back({CMD_DMA_WRITE, 6'h3f, 16'hffff, 1'b1, 2'd3,
                        1'b1, 16'hffff, 1'b0, 3'd0, 8'h00, 8'h00});
        // arm for reads and clear the latch
        plan.push_back({CMD_REG_WRITE, 6'h3f, 16'hffff, 1'b1, 2'd3,
                        1'b1, 16'hffff, 1'b1, 3'd7, 8'hff, 8'h00});
        plan.push_back({CMD_DRQ_CHANGE, 6'h00, 16'h0000, 1'b1, 2'd0,
                        1'b0, 16'h0000, 1'b0, 3'd0, 8'h00, 8'h00});
        // burst capped at two bytes
        plan.push_back({CMD_DMA_READ, 6'h00, 16'ha55a, 1'b0, 2'd3,
                        1'b0, 16'h0000, 1'b0, 3'd0, 8'h00, 8'h00});
        // short burst, drq drops, host stalled
        plan.push_back({CMD_DMA_READ, 6'h15, 16'h1234, 1'b0, 2'd1,
                        1'b0, 16'h0000, 1'b0, 3'd0, 8'h00, 8'h00});
        plan.push_back({CMD_STATUS, 6'h00, 16'h0000, 1'b0, 2'd0,
                        1'b0, 16'h0000, 1'b0, 3'd0, 8'h00, 8'h00});
        plan.push_back({CMD_DRQ_CHANGE, 6'h00, 16'h5600, 1'b1, 2'd0,
                        1'b0, 16'h0000, 1'b0, 3'd0, 8'h00, 8'h00});
        plan.push_back({CMD_DMA_READ, 6'h00, 16'h0000, 1'b0, 2'd2,
                        1'b0, 16'h0000, 1'b0, 3'd0, 8'h00, 8'h00});
        // arm for writes
        plan.push_back({CMD_REG_WRITE, 6'h0a, 16'h0000, 1'b0, 2'd0,
                        1'b1, 16'hffff, 1'b1, 3'd5, 8'h00, 8'h00});
        plan.push_back({CMD_DMA_WRITE, 6'h00, 16'hbeef, 1'b0, 2'd0,
                        1'b0, 16'h0000, 1'b0, 3'd0, 8'h00, 8'h00});
        plan.push_back({CMD_DRQ_CHANGE, 6'h00, 16'h0000, 1'b0, 2'd0,
                        1'b0, 16'h0000, 1'b0, 3'd0, 8'h00, 8'h00});
        plan.push_back({CMD_DRQ_CHANGE, 6'h00, 16'h0000, 1'b1, 2'd0,
                        1'b0, 16'h0000, 1'b0, 3'd0, 8'h00, 8'h00});
        // irq aborts mid-word
        plan.push_back({CMD_IRQ_CHANGE, 6'h00, 16'h0000, 1'b1, 2'd0,
                        1'b0, 16'h0000, 1'b0, 3'd0, 8'h00, 8'h00});
        plan.push_back({CMD_DMA_WRITE, 6'h00, 16'h0000, 1'b0, 2'd2,
                        1'b1, 16'hffff, 1'b0, 3'd0, 8'h00, 8'h00});
        // register 7 without the clear bit
        plan.push_back({CMD_REG_WRITE, 6'h0e, 16'h5a80, 1'b0, 2'd1,
                        1'b1, 16'hffff, 1'b1, 3'd7, 8'h80, 8'h00});
        plan.push_back({CMD_STATUS, 6'h00, 16'h0000, 1'b0, 2'd0,
                        1'b0, 16'h0000, 1'b0, 3'd0, 8'h00, 8'h00});
        plan.push_back({CMD_DMA_WRITE, 6'h00, 16'h0000, 1'b0, 2'd2,
                        1'b0, 16'h0000, 1'b0, 3'd0, 8'h00, 8'h00});
        plan.push_back({CMD_IRQ_CHANGE, 6'h00, 16'h0000, 1'b0, 2'd0,
                        1'b0, 16'h0000, 1'b0, 3'd0, 8'h00, 8'h00});
        plan.push_back({CMD_BUS_RESET, 6'h2a, 16'h55aa, 1'b1, 2'd2,
                        1'b0, 16'h0000, 1'b0, 3'd0, 8'h00, 8'h00});
        plan.push_back({CMD_UNUSED, 6'h3f, 16'hffff, 1'b1, 2'd3,
                        1'b1, 16'hffff, 1'b0, 3'd0, 8'h00, 8'h00});
        plan.push_back({CMD_STATUS, 6'h00, 16'h0000, 1'b0, 2'd0,
                        1'b1, 16'hffff, 1'b0, 3'd0, 8'h00, 8'ha0});
        plan.push_back({CMD_REG_WRITE, 6'h00, 16'h00ff, 1'b0, 2'd0,
                        1'b1, 16'hffff, 1'b1, 3'd0, 8'hff, 8'h00});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            tr = '0;
            tr.read_word = row.t_read;
            tr.reg_forward_valid = row.t_fwd;
            tr.reg_index = row.t_idx;
            tr.reg_data = row.t_data;
            tr.host_ready = 1'b1;
            tr.status_byte = row.t_status;
            send(row.it, row.typed, tr);
        end
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_jumpers(3'd0, 1'b1, 1'b0);
                1: set_jumpers(3'd7, 1'b0, 1'b1);
                default: set_jumpers(ID_W'($urandom_range(7)), 1'($urandom_range(1)),
                                     1'($urandom_range(1)));
            endcase
            sender_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 60 : 37) : 0;
            stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 60 : 37) : 0;
            // long receiver hold-off so the block backs up into the input
            if (phase == 0)
                hold_request = 150;
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
            begin
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(1, 3)) send(noise_item());
                else
                    transfer_burst();
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (failures == 0 && pending.size() == 0)
            $display("tb_pseudo_dma_word_byte_latch passed");
        else
            $display("tb_pseudo_dma_word_byte_latch failed");
        $finish;
    end

endmodule
